// ----- rtl/fcce_pkg.sv -----
// Shared types and constants for the cluster link table engine.
// Depends on nothing; the core and the testbench import it.
package fcce_pkg;

   localparam int TABLE_DEPTH   = 4096;
   localparam int CLUSTER_SPACE = 4096;
   localparam int SPAN          = (TABLE_DEPTH < CLUSTER_SPACE) ? TABLE_DEPTH : CLUSTER_SPACE;
   localparam int ADDR_W        = $clog2(SPAN);
   localparam int CLUSTER_W     = 12;
   localparam int LINK_W        = 16;
   localparam int CNT_W         = CLUSTER_W + 1;

   localparam logic [LINK_W-1:0] LINK_FREE = 16'h0000;
   localparam logic [LINK_W-1:0] LINK_RSV0 = 16'hfffd;
   localparam logic [LINK_W-1:0] LINK_RSV  = 16'hfffe;
   localparam logic [LINK_W-1:0] LINK_END  = 16'hffff;

   localparam logic [CLUSTER_W-1:0] FIRST_DATA_RST = 12'd10;

   localparam logic [2:0] KIND_ALLOC  = 3'd0;
   localparam logic [2:0] KIND_EXTEND = 3'd1;
   localparam logic [2:0] KIND_FREE   = 3'd2;
   localparam logic [2:0] KIND_TRUNC  = 3'd3;
   localparam logic [2:0] KIND_TAIL   = 3'd4;
   localparam logic [2:0] KIND_READ   = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   typedef struct packed {
      logic [2:0]           kind;
      logic [CLUSTER_W-1:0] cluster;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [CLUSTER_W-1:0] result_cluster;
      logic [LINK_W-1:0]    entry_value;
      logic [CNT_W-1:0]     freed_count;
   } rsp_type;

endpackage

// ----- rtl/fat_cluster_chain_engine_core.sv -----
// Cluster link table engine: top level with the command sequencer and the link RAM.
// Depends on fcce_pkg and fcce_ram.
// Throughput: one request at a time, one link RAM read per cycle; the next request is taken
// in the cycle its predecessor's result appears. Per request: read checks the entry;
// allocate runs the free scan; extend checks the chain end, scans, then links the old tail;
// find tail walks the chain; free and truncate walk it (up to 4096 entries), then erase it;
// a bad head goes straight to the result. Reset: synchronous; afterwards a clearing pass
// writes the initial link table, taking no request until done (csr writes taken throughout).
module fat_cluster_chain_engine_core
   import fcce_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CLUSTER_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_CHK, S_SCAN, S_LINK, S_WALK, S_ERASE, S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [CLUSTER_W-1:0] fdc_ff, fdc_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic [2:0]           kind_ff, kind_in;
   logic [CLUSTER_W-1:0] cl_ff, cl_in;
   logic [ADDR_W-1:0]    cur_ff, cur_in;
   logic [CNT_W-1:0]     len_ff, len_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic [CNT_W-1:0]     chk_ff, chk_in;
   logic                 prime_ff, prime_in;
   logic                 first_ff, first_in;
   rsp_type              work_ff, work_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // link RAM ports
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [LINK_W-1:0]    wr_data;
   logic [ADDR_W-1:0]    rd_addr;
   logic [LINK_W-1:0]    rd_data;

   // Initial table: reserved marks in the low entries, end mark at 9, rest free.
   function automatic logic [LINK_W-1:0] rst_link(input logic [ADDR_W-1:0] a);
      logic [LINK_W-1:0] v;
      v = LINK_FREE;
      if (a == '0) begin
         v = LINK_RSV0;
      end else if (a < ADDR_W'(9)) begin
         v = LINK_RSV;
      end else if (a == ADDR_W'(9)) begin
         v = LINK_END;
      end
      return v;
   endfunction

   // A link may point here: at or above the first data cluster and inside the table.
   function automatic logic in_area(input logic [LINK_W-1:0] v,
                                    input logic [CLUSTER_W-1:0] fdc);
      return (v >= {{(LINK_W-CLUSTER_W){1'b0}}, fdc}) && (v < LINK_W'(SPAN));
   endfunction

   fcce_ram #(
      .WIDTH (LINK_W),
      .DEPTH (SPAN)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      fdc_in       = fdc_ff;
      clr_in       = clr_ff;
      kind_in      = kind_ff;
      cl_in        = cl_ff;
      cur_in       = cur_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      scan_in      = scan_ff;
      chk_in       = chk_ff;
      prime_in     = prime_ff;
      first_in     = first_ff;
      work_in      = work_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      wr_data      = LINK_FREE;
      rd_addr      = cur_ff;

      if (csr_valid) begin
         fdc_in = csr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            // write the initial table, one entry a cycle
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = rst_link(clr_ff);
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(SPAN - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rd_addr = ADDR_W'(req_data.cluster);
            if (req_valid) begin
               kind_in                    = req_data.kind;
               cl_in                      = req_data.cluster;
               cur_in                     = ADDR_W'(req_data.cluster);
               len_in                     = CNT_W'(1);
               scan_in                    = {1'b0, fdc_ff};
               prime_in                   = 1'b1;
               work_in.status             = ST_BAD;
               work_in.result_cluster     = req_data.cluster;
               work_in.entry_value        = '0;
               work_in.freed_count        = '0;
               unique case (req_data.kind)
                  KIND_ALLOC: begin
                     state_in = S_SCAN;
                  end
                  KIND_EXTEND: begin
                     state_in = in_area(LINK_W'(req_data.cluster), fdc_ff) ? S_CHK : S_DONE;
                  end
                  KIND_FREE, KIND_TRUNC, KIND_TAIL: begin
                     state_in = in_area(LINK_W'(req_data.cluster), fdc_ff) ? S_WALK : S_DONE;
                  end
                  KIND_READ: begin
                     state_in = (LINK_W'(req_data.cluster) < LINK_W'(SPAN)) ? S_CHK : S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_CHK: begin
            if (kind_ff == KIND_EXTEND) begin
               // only a chain end may be extended
               state_in = (rd_data == LINK_END) ? S_SCAN : S_DONE;
            end else begin
               work_in.status      = ST_OK;
               work_in.entry_value = rd_data;
               state_in            = S_DONE;
            end
         end
         S_SCAN: begin
            // issue the next address while checking the one read last cycle
            rd_addr  = ADDR_W'(scan_ff);
            scan_in  = scan_ff + CNT_W'(1);
            chk_in   = scan_ff;
            prime_in = 1'b0;
            if (!prime_ff) begin
               if (chk_ff >= CNT_W'(SPAN)) begin
                  work_in.status = ST_FULL;
                  state_in       = S_DONE;
               end else if (rd_data == LINK_FREE) begin
                  wr_en                  = 1'b1;
                  wr_addr                = ADDR_W'(chk_ff);
                  wr_data                = LINK_END;
                  work_in.status         = ST_OK;
                  work_in.result_cluster = CLUSTER_W'(chk_ff);
                  state_in               = (kind_ff == KIND_EXTEND) ? S_LINK : S_DONE;
               end
            end
         end
         S_LINK: begin
            // hook the old tail to the new entry
            wr_en    = 1'b1;
            wr_addr  = ADDR_W'(cl_ff);
            wr_data  = LINK_W'(work_ff.result_cluster);
            state_in = S_DONE;
         end
         S_WALK: begin
            if (rd_data == LINK_END) begin
               if (kind_ff == KIND_TAIL) begin
                  work_in.status         = ST_OK;
                  work_in.result_cluster = CLUSTER_W'(cur_ff);
                  state_in               = S_DONE;
               end else begin
                  // chain checked: walk it again from the head and erase
                  rd_addr  = ADDR_W'(cl_ff);
                  cur_in   = ADDR_W'(cl_ff);
                  cnt_in   = len_ff;
                  first_in = 1'b1;
                  state_in = S_ERASE;
               end
            end else if (rd_data == LINK_FREE || !in_area(rd_data, fdc_ff) ||
                         len_ff >= CNT_W'(SPAN)) begin
               state_in = S_DONE;
            end else begin
               rd_addr = ADDR_W'(rd_data);
               cur_in  = ADDR_W'(rd_data);
               len_in  = len_ff + CNT_W'(1);
            end
         end
         S_ERASE: begin
            // truncate keeps the head as the new end
            wr_en    = 1'b1;
            wr_addr  = cur_ff;
            wr_data  = (first_ff && kind_ff == KIND_TRUNC) ? LINK_END : LINK_FREE;
            rd_addr  = ADDR_W'(rd_data);
            cur_in   = ADDR_W'(rd_data);
            cnt_in   = cnt_ff - CNT_W'(1);
            first_in = 1'b0;
            if (cnt_ff == CNT_W'(1)) begin
               work_in.status      = ST_OK;
               work_in.freed_count = (kind_ff == KIND_TRUNC) ? len_ff - CNT_W'(1) : len_ff;
               state_in            = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = work_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         fdc_ff       <= FIRST_DATA_RST;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         prime_ff     <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fdc_ff       <= fdc_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         prime_ff     <= prime_in;
         first_ff     <= first_in;
      end
      kind_ff <= kind_in;
      cl_ff   <= cl_in;
      cur_ff  <= cur_in;
      len_ff  <= len_in;
      cnt_ff  <= cnt_in;
      scan_ff <= scan_in;
      chk_ff  <= chk_in;
      work_ff <= work_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ----- rtl/fcce_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module fcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- verif/tb_fat_cluster_chain_engine_core.sv -----
// Self-checking testbench for the cluster link table engine: directed vectors, then random
// command streams under four first-data settings. Depends on fcce_pkg and the core RTL.
module tb_fat_cluster_chain_engine_core
   import fcce_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PERIOD       = 20;
   localparam int STALL_LIMIT  = 40000;  // clearing pass plus a full-length free, with margin
   localparam int PHASE_ITEMS  = 28;
   localparam int REPORT_LIMIT = 10;

   // Command codes the package leaves unnamed; the engine must reject both.
   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   typedef struct {
      bit                   set_cfg;
      logic [CLUSTER_W-1:0] cfg;
      req_type              cmd;
      bit                   typed;
      rsp_type              want;
   } vector_row_type;

   typedef struct {
      req_type cmd;
      rsp_type reply;
   } reply_due_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CLUSTER_W-1:0] csr_data = '0;

   // Shadow of the engine: link table and first-data register.
   logic [LINK_W-1:0]    link_shadow [0:SPAN-1];
   logic [CLUSTER_W-1:0] first_data_shadow;

   vector_row_type directed_rows [$];
   reply_due_type  replies_due [$];
   bit             row_typed = 1'b0;
   rsp_type        row_reply = '0;
   bit             calm = 1'b0;
   int             mismatch_count = 0;
   int             quiet_cycles = 0;

   fat_cluster_chain_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #(PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Shadow table model
   // ---------------------------------------------------------------------------------------

   function automatic void reset_shadow();
      for (int i = 0; i < SPAN; i++) begin
         link_shadow[i] = LINK_FREE;
      end
      link_shadow[0] = LINK_RSV0;
      for (int i = 1; i < 9; i++) begin
         link_shadow[i] = LINK_RSV;
      end
      link_shadow[9] = LINK_END;
      first_data_shadow = FIRST_DATA_RST;
   endfunction

   // A cluster may sit in a chain only at or above first-data and inside the table.
   function automatic bit chain_slot(int c);
      return c >= int'(first_data_shadow) && c < SPAN;
   endfunction

   // Walk a chain; return its length, or zero when the chain is broken.
   function automatic int chain_length(int head, output int tail);
      int          cur;
      int          n;
      logic [15:0] v;
      tail = 0;
      if (!chain_slot(head)) return 0;
      cur = head;
      n = 1;
      while (1'b1) begin
         v = link_shadow[cur];
         if (v == LINK_END) begin
            tail = cur;
            return n;
         end
         if (v == LINK_FREE || !chain_slot(int'(v)) || n >= SPAN) return 0;
         cur = int'(v);
         n++;
      end
      return 0;
   endfunction

   function automatic int lowest_free();
      for (int c = int'(first_data_shadow); c < SPAN; c++) begin
         if (link_shadow[c] == LINK_FREE) return c;
      end
      return SPAN;
   endfunction

   function automatic void clear_chain(int c, int count);
      logic [LINK_W-1:0] nx;
      while (count > 0) begin
         nx = link_shadow[c];
         link_shadow[c] = LINK_FREE;
         c = int'(nx);
         count--;
      end
   endfunction

   // Apply one command to the shadow table and return the reply it must produce.
   function automatic rsp_type apply_command(req_type r);
      rsp_type o;
      int      c;
      int      nc;
      int      n;
      int      tail;
      c = int'(r.cluster);
      o.status         = ST_BAD;
      o.result_cluster = r.cluster;
      o.entry_value    = '0;
      o.freed_count    = '0;
      case (r.kind)
         KIND_ALLOC: begin
            nc = lowest_free();
            if (nc < SPAN) begin
               link_shadow[nc]  = LINK_END;
               o.status         = ST_OK;
               o.result_cluster = CLUSTER_W'(nc);
            end else begin
               o.status = ST_FULL;
            end
         end
         KIND_EXTEND: begin
            if (chain_slot(c) && link_shadow[c] == LINK_END) begin
               nc = lowest_free();
               if (nc < SPAN) begin
                  link_shadow[nc]  = LINK_END;
                  link_shadow[c]   = LINK_W'(nc);
                  o.status         = ST_OK;
                  o.result_cluster = CLUSTER_W'(nc);
               end else begin
                  o.status = ST_FULL;
               end
            end
         end
         KIND_FREE: begin
            n = chain_length(c, tail);
            if (n != 0) begin
               clear_chain(c, n);
               o.status      = ST_OK;
               o.freed_count = CNT_W'(n);
            end
         end
         KIND_TRUNC: begin
            n = chain_length(c, tail);
            if (n != 0) begin
               if (n > 1) clear_chain(int'(link_shadow[c]), n - 1);
               link_shadow[c] = LINK_END;
               o.status       = ST_OK;
               o.freed_count  = CNT_W'(n - 1);
            end
         end
         KIND_TAIL: begin
            n = chain_length(c, tail);
            if (n != 0) begin
               o.status         = ST_OK;
               o.result_cluster = CLUSTER_W'(tail);
            end
         end
         KIND_READ: begin
            if (c < SPAN) begin
               o.status      = ST_OK;
               o.entry_value = link_shadow[c];
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------

   function automatic void add_row(bit set_cfg, int cfg, logic [2:0] kind, int cluster,
                                   bit typed, logic [1:0] st, int res, int entry, int freed);
      vector_row_type row;
      row.set_cfg             = set_cfg;
      row.cfg                 = CLUSTER_W'(cfg);
      row.cmd.kind            = kind;
      row.cmd.cluster         = CLUSTER_W'(cluster);
      row.typed               = typed;
      row.want.status         = st;
      row.want.result_cluster = CLUSTER_W'(res);
      row.want.entry_value    = LINK_W'(entry);
      row.want.freed_count    = CNT_W'(freed);
      directed_rows.push_back(row);
   endfunction

   // Pick a live cluster near the allocation front: a chain end, or any used entry.
   function automatic logic [CLUSTER_W-1:0] live_cluster(bit want_end);
      int lo;
      int hi;
      int base;
      int idx;
      lo = int'(first_data_shadow);
      hi = (lo + 127 > SPAN - 1) ? SPAN - 1 : lo + 127;
      base = int'($urandom_range(hi, lo));
      for (int k = 0; k < SPAN - lo; k++) begin
         idx = lo + (base - lo + k) % (SPAN - lo);
         if (want_end ? link_shadow[idx] == LINK_END : link_shadow[idx] != LINK_FREE)
            return CLUSTER_W'(idx);
      end
      return CLUSTER_W'(base);
   endfunction

   // Mostly well-formed commands on live chains; a fifth, and every allocate, go to random clusters.
   function automatic req_type random_command();
      req_type r;
      int      w;
      int      lo;
      w = int'($urandom_range(99));
      if (w < 18)      r.kind = KIND_ALLOC;
      else if (w < 42) r.kind = KIND_EXTEND;
      else if (w < 54) r.kind = KIND_FREE;
      else if (w < 66) r.kind = KIND_TRUNC;
      else if (w < 80) r.kind = KIND_TAIL;
      else if (w < 93) r.kind = KIND_READ;
      else             r.kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
      lo = int'(first_data_shadow);
      if ($urandom_range(99) < 20 || r.kind == KIND_ALLOC) begin
         r.cluster = CLUSTER_W'($urandom_range(SPAN - 1));
      end else if (r.kind == KIND_EXTEND) begin
         r.cluster = live_cluster(1'b1);
      end else if (r.kind == KIND_READ) begin
         r.cluster = CLUSTER_W'($urandom_range((lo + 127 > SPAN - 1) ? SPAN - 1 : lo + 127));
      end else begin
         r.cluster = live_cluster(1'b0);
      end
      return r;
   endfunction

   // Present one request, idling first at random; return at the falling edge after it is
   // taken, so the shadow already holds its effect.
   task automatic send_request(input req_type r);
      while (!calm && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid and hold until every reply is back, then let the engine settle.
   task automatic drain(input int extra);
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_first_data(input logic [CLUSTER_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // Reply side: random back-pressure, except in the calm phase.
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 17);
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: check each reply against the oldest one due, then predict for new requests.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      reply_due_type got;
      reply_due_type due;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected reply: status %0d cluster %0d entry %h freed %0d",
                           rsp_data.status, rsp_data.result_cluster, rsp_data.entry_value,
                           rsp_data.freed_count);
            end else begin
               due = replies_due.pop_front();
               if (rsp_data.status != due.reply.status
                   || rsp_data.result_cluster != due.reply.result_cluster
                   || rsp_data.entry_value != due.reply.entry_value
                   || rsp_data.freed_count != due.reply.freed_count) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("reply mismatch for kind %0d cluster %0d: expected %s",
                              due.cmd.kind, due.cmd.cluster,
                              $sformatf("st %0d cl %0d ent %h freed %0d",
                                        due.reply.status, due.reply.result_cluster,
                                        due.reply.entry_value, due.reply.freed_count));
                     $display("   got st %0d cl %0d ent %h freed %0d",
                              rsp_data.status, rsp_data.result_cluster,
                              rsp_data.entry_value, rsp_data.freed_count);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) first_data_shadow = csr_data;
         if (req_valid && req_ready) begin
            // Always advance the shadow; a hand-typed reply overrides its prediction.
            got.cmd   = req_data;
            got.reply = apply_command(req_data);
            if (row_typed) got.reply = row_reply;
            replies_due.push_back(got);
         end
      end
   end

   // Watchdog: count cycles in which no channel moves anything.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      logic [CLUSTER_W-1:0] phase_cfg [4];
      req_type              cmd;

      reset_shadow();

      // Reset table, first-data at its reset value.
      add_row(0, 0, KIND_READ,     0,    1, ST_OK,  0,    16'hfffd, 0);
      add_row(0, 0, KIND_READ,     4095, 1, ST_OK,  4095, 0,        0);
      add_row(0, 0, KIND_READ,     9,    1, ST_OK,  9,    16'hffff, 0);
      add_row(0, 0, KIND_ALLOC,    0,    1, ST_OK,  10,   0,        0);
      add_row(0, 0, KIND_ALLOC,    4095, 1, ST_OK,  11,   0,        0);
      add_row(0, 0, KIND_EXTEND,   10,   1, ST_OK,  12,   0,        0);
      add_row(0, 0, KIND_EXTEND,   12,   1, ST_OK,  13,   0,        0);
      add_row(0, 0, KIND_EXTEND,   11,   0, ST_OK,  0,    0,        0);
      add_row(0, 0, KIND_TAIL,     10,   1, ST_OK,  13,   0,        0);
      // Extend of a cluster that is not a chain end.
      add_row(0, 0, KIND_EXTEND,   10,   1, ST_BAD, 10,   0,        0);
      // Head below first-data, and a head that is a free entry.
      add_row(0, 0, KIND_TAIL,     9,    1, ST_BAD, 9,    0,        0);
      add_row(0, 0, KIND_FREE,     20,   1, ST_BAD, 20,   0,        0);
      add_row(0, 0, KIND_TRUNC,    10,   0, ST_OK,  0,    0,        0);
      add_row(0, 0, KIND_FREE,     11,   0, ST_OK,  0,    0,        0);
      add_row(0, 0, KIND_SPARE_LO, 4095, 1, ST_BAD, 4095, 0,        0);
      add_row(0, 0, KIND_SPARE_HI, 0,    1, ST_BAD, 0,    0,        0);
      add_row(0, 0, KIND_TRUNC,    10,   0, ST_OK,  0,    0,        0);
      add_row(0, 0, KIND_FREE,     10,   0, ST_OK,  0,    0,        0);
      // Only the top cluster is allocatable: fill it, then hit table full.
      add_row(1, 4095, KIND_ALLOC, 0,    1, ST_OK,   4095, 0,       0);
      add_row(0, 0, KIND_ALLOC,    123,  1, ST_FULL, 123,  0,       0);
      add_row(0, 0, KIND_EXTEND,   4095, 1, ST_FULL, 4095, 0,       0);
      add_row(0, 0, KIND_TAIL,     4095, 1, ST_OK,   4095, 0,       0);
      add_row(0, 0, KIND_FREE,     4095, 1, ST_OK,   4095, 0,       1);
      // Lowest first-data: reserved marks become reachable as chain heads.
      add_row(1, 1, KIND_READ,     5,    1, ST_OK,  5,    16'hfffe, 0);
      add_row(0, 0, KIND_TAIL,     8,    1, ST_BAD, 8,    0,        0);
      add_row(0, 0, KIND_FREE,     9,    1, ST_OK,  9,    0,        1);
      add_row(0, 0, KIND_ALLOC,    0,    0, ST_OK,  0,    0,        0);

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_cfg) begin
            drain(8);
            write_first_data(directed_rows[i].cfg);
         end
         row_typed = directed_rows[i].typed;
         row_reply = directed_rows[i].want;
         send_request(directed_rows[i].cmd);
      end

      // Random phases; raising first-data strands old links and breaks chains.
      phase_cfg[0] = FIRST_DATA_RST;
      phase_cfg[1] = CLUSTER_W'($urandom_range(40, 1));
      phase_cfg[2] = CLUSTER_W'($urandom_range(80, 11));
      phase_cfg[3] = 12'd1;
      row_typed = 1'b0;
      for (int p = 0; p < 4; p++) begin
         drain(8);
         write_first_data(phase_cfg[p]);
         calm = (p == 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            cmd = random_command();
            send_request(cmd);
         end
      end

      drain(16);
      if (mismatch_count == 0 && replies_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/fcce_pkg.sv
rtl/fcce_ram.sv
rtl/fat_cluster_chain_engine_core.sv
verif/tb_fat_cluster_chain_engine_core.sv
